// ----- src/edpm_pkg.sv -----
// ----------------------------------------------------------------------------
// edpm_pkg
// Types, codes and transition tables of the protocol-controller mode machine.
// ----------------------------------------------------------------------------
`default_nettype none

package edpm_pkg;

   localparam int unsigned EV_W     = 31;
   localparam int unsigned N_TRANS  = 20;
   localparam int unsigned TIDX_W   = 5;
   localparam int unsigned STATE_W  = 4;
   localparam int unsigned ACTION_W = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_POST       = 2'd0,
      ACT_EVAL       = 2'd1,
      ACT_START      = 2'd2,
      ACT_SOFT_RESET = 2'd3
   } action_type;

   typedef enum logic [10:0] {
      MODE_FREEZE       = 11'b000_0000_0001,
      MODE_INIT         = 11'b000_0000_0010,
      MODE_LISTEN       = 11'b000_0000_0100,
      MODE_COLDSTART    = 11'b000_0000_1000,
      MODE_SUBCOLDSTART = 11'b000_0001_0000,
      MODE_ACTIVE       = 11'b000_0010_0000,
      MODE_PASSIVE      = 11'b000_0100_0000,
      MODE_AWAIT        = 11'b000_1000_0000,
      MODE_TEST         = 11'b001_0000_0000,
      MODE_DOWNLOAD     = 11'b010_0000_0000,
      MODE_ERROR        = 11'b100_0000_0000
   } mode_type;

   // Outcome of one evaluate, handed from the evaluation logic to the top level.
   typedef struct packed {
      logic              fired;
      logic [TIDX_W-1:0] tidx;
      logic [EV_W-1:0]   pending;
      mode_type          mode;
   } eval_type;

   localparam logic [EV_W-1:0] CLEAR_MASK [N_TRANS] = '{
      31'h7ffffbff, 31'h7ffffffe, 31'h7ffffffd, 31'h7fffffe3,
      31'h7ffffc1f, 31'h7fffa7ff, 31'h7fffffdf, 31'h7fff1fff,
      31'h7ffeffff, 31'h7ff9ffff, 31'h7ff7ffff, 31'h7feffdff,
      31'h7f9bffff, 31'h7f7fffff, 31'h7effffff, 31'h7dffffff,
      31'h7fffffbf, 31'h73ffdfff, 31'h7fffffe7, 31'h7fff97ff
   };

   localparam mode_type TARGET_MODE [N_TRANS] = '{
      MODE_FREEZE, MODE_LISTEN, MODE_PASSIVE, MODE_COLDSTART,
      MODE_FREEZE, MODE_ACTIVE, MODE_LISTEN, MODE_PASSIVE,
      MODE_ACTIVE, MODE_TEST, MODE_FREEZE, MODE_AWAIT,
      MODE_INIT, MODE_FREEZE, MODE_DOWNLOAD, MODE_FREEZE,
      MODE_SUBCOLDSTART, MODE_LISTEN, MODE_COLDSTART, MODE_PASSIVE
   };

   function automatic logic [N_TRANS-1:0] allow_mask(input mode_type m);
      logic [N_TRANS-1:0] a;
      unique case (m)
         MODE_FREEZE:       a = 20'h01a00;
         MODE_INIT:         a = 20'h00403;
         MODE_LISTEN:       a = 20'h0400d;
         MODE_COLDSTART:    a = 20'h90061;
         MODE_SUBCOLDSTART: a = 20'h60001;
         MODE_ACTIVE:       a = 20'h00091;
         MODE_PASSIVE:      a = 20'h00111;
         MODE_AWAIT:        a = 20'h04001;
         MODE_TEST:         a = 20'h02001;
         MODE_DOWNLOAD:     a = 20'h08001;
         default:           a = '0;
      endcase
      return a;
   endfunction

   function automatic logic [STATE_W-1:0] mode_number(input mode_type m);
      logic [STATE_W-1:0] n;
      unique case (m)
         MODE_FREEZE:       n = 4'd0;
         MODE_INIT:         n = 4'd1;
         MODE_LISTEN:       n = 4'd2;
         MODE_COLDSTART:    n = 4'd3;
         MODE_SUBCOLDSTART: n = 4'd4;
         MODE_ACTIVE:       n = 4'd5;
         MODE_PASSIVE:      n = 4'd6;
         MODE_AWAIT:        n = 4'd7;
         MODE_TEST:         n = 4'd8;
         MODE_DOWNLOAD:     n = 4'd9;
         default:           n = 4'd10;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- src/edpm_if.sv -----
// ----------------------------------------------------------------------------
// edpm_req_if / edpm_rsp_if
// Valid/ready channels for commands into and results out of the mode machine.
// ----------------------------------------------------------------------------
`default_nettype none

interface edpm_req_if import edpm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [EV_W-1:0]     event_bits;
   logic                sticky;

   modport source (output valid, action, event_bits, sticky, input ready);
   modport sink   (input valid, action, event_bits, sticky, output ready);
endinterface

interface edpm_rsp_if import edpm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [STATE_W-1:0] state_number;
   logic               fired;
   logic [TIDX_W-1:0]  transition_index;
   logic               running;

   modport source (output valid, state_number, fired, transition_index, running,
                   input ready);
   modport sink   (input valid, state_number, fired, transition_index, running,
                   output ready);
endinterface

`default_nettype wire

// ----- src/edpm_eval.sv -----
// ----------------------------------------------------------------------------
// edpm_eval
// Transition conditions, mode masking, lowest-index priority and event clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module edpm_eval import edpm_pkg::*; (
   input  logic [EV_W-1:0] pending,
   input  logic [EV_W-1:0] permanent,
   input  mode_type        mode,
   output eval_type        result
);

   logic [N_TRANS-1:0] cond;
   logic [N_TRANS-1:0] act;
   logic [TIDX_W-1:0]  k;

   // Event n sits in bit n-1 of the pending set.
   always_comb begin
      cond[0]  = pending[10];
      cond[1]  = pending[0];
      cond[2]  = pending[1];
      cond[3]  = pending[2] & pending[3] & pending[4];
      cond[4]  = |pending[9:5];
      cond[5]  = pending[11] & pending[12] & pending[14];
      cond[6]  = pending[5];
      cond[7]  = |pending[15:13];
      cond[8]  = pending[16];
      cond[9]  = pending[17] & pending[18];
      cond[10] = pending[19];
      cond[11] = pending[20] & pending[18];
      cond[12] = pending[21] & pending[22] & pending[18];
      cond[13] = pending[23];
      cond[14] = pending[24];
      cond[15] = pending[25];
      cond[16] = pending[6];
      cond[17] = pending[26] & pending[27] & pending[13];
      cond[18] = pending[3] & pending[4];
      cond[19] = pending[11] & (pending[13] | pending[14]);
   end

   assign act = cond & allow_mask(mode);

   // Scan from the top so the lowest active transition is written last.
   always_comb begin
      k = '0;
      for (int i = N_TRANS - 1; i >= 0; i--) begin
         if (act[i]) begin
            k = TIDX_W'(i);
         end
      end
   end

   always_comb begin
      result.fired = |act;
      result.tidx  = k;
      if (result.fired) begin
         result.pending = (pending & CLEAR_MASK[k]) | permanent;
         result.mode    = TARGET_MODE[k];
      end else begin
         result.pending = pending;
         result.mode    = mode;
      end
   end

endmodule

`default_nettype wire

// ----- src/event_driven_protocol_mode_fsm.sv -----
// ----------------------------------------------------------------------------
// event_driven_protocol_mode_fsm
// Eleven-mode protocol-controller state machine driven by posted events.
// ----------------------------------------------------------------------------
// One command is taken per clock cycle while the input register is free or
// moving on, and each command produces exactly one result: the command is
// captured in an input register, the event sets and mode are updated by a
// single level of condition, mask and priority logic, and the result lands
// in an output register. Commands are taken while a result is still waiting
// on the output, so the sustained rate is one transaction per cycle whenever
// the result side is ready. Post adds events (sticky posts also become
// permanent), evaluate fires the lowest allowed transition, start leaves the
// error mode once, and soft reset returns the event sets, mode and running
// flag to the reset state.
`default_nettype none

module event_driven_protocol_mode_fsm import edpm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   edpm_req_if.sink   req_chan,
   edpm_rsp_if.source rsp_chan
);

   logic               in_vld_ff;
   action_type         in_action_ff;
   logic [EV_W-1:0]    in_bits_ff;
   logic               in_sticky_ff;

   logic [EV_W-1:0]    pend_ff, pend_in;
   logic [EV_W-1:0]    perm_ff, perm_in;
   mode_type           mode_ff, mode_in;
   logic               started_ff, started_in;

   logic               out_vld_ff;
   logic [STATE_W-1:0] out_state_ff;
   logic               out_fired_ff, fired_in;
   logic [TIDX_W-1:0]  out_tidx_ff, tidx_in;
   logic               out_running_ff;

   logic               advance;
   logic               req_take;
   eval_type           eval_res;

   assign advance          = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready   = !in_vld_ff || advance;
   assign req_take         = req_chan.valid && req_chan.ready;

   edpm_eval u_eval (
      .pending   (pend_ff),
      .permanent (perm_ff),
      .mode      (mode_ff),
      .result    (eval_res)
   );

   always_comb begin
      pend_in    = pend_ff;
      perm_in    = perm_ff;
      mode_in    = mode_ff;
      started_in = started_ff;
      fired_in   = 1'b0;
      tidx_in    = '0;
      unique case (in_action_ff)
         ACT_POST: begin
            if (in_sticky_ff) begin
               perm_in = perm_ff | in_bits_ff;
            end
            pend_in = pend_ff | in_bits_ff | perm_in;
         end
         ACT_EVAL: begin
            if (eval_res.fired) begin
               pend_in  = eval_res.pending;
               mode_in  = eval_res.mode;
               fired_in = 1'b1;
               tidx_in  = eval_res.tidx;
            end
         end
         ACT_START: begin
            if (!started_ff) begin
               mode_in    = MODE_FREEZE;
               started_in = 1'b1;
            end
         end
         ACT_SOFT_RESET: begin
            pend_in    = '0;
            perm_in    = '0;
            mode_in    = MODE_ERROR;
            started_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         pend_ff    <= '0;
         perm_ff    <= '0;
         mode_ff    <= MODE_ERROR;
         started_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_vld_ff <= 1'b1;
         end else if (advance) begin
            in_vld_ff <= 1'b0;
         end
         if (advance) begin
            out_vld_ff <= 1'b1;
            pend_ff    <= pend_in;
            perm_ff    <= perm_in;
            mode_ff    <= mode_in;
            started_ff <= started_in;
         end else if (rsp_chan.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= action_type'(req_chan.action);
         in_bits_ff   <= req_chan.event_bits;
         in_sticky_ff <= req_chan.sticky;
      end
      if (advance) begin
         out_state_ff   <= mode_number(mode_in);
         out_fired_ff   <= fired_in;
         out_tidx_ff    <= tidx_in;
         out_running_ff <= started_in;
      end
   end

   assign rsp_chan.valid            = out_vld_ff;
   assign rsp_chan.state_number     = out_state_ff;
   assign rsp_chan.fired            = out_fired_ff;
   assign rsp_chan.transition_index = out_tidx_ff;
   assign rsp_chan.running          = out_running_ff;

   // Until started, the machine must sit in the error mode.
   a_idle_in_error: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> mode_ff == MODE_ERROR)
      else $error("mode left error without a start");

   // Permanent events are always present in the pending set.
   a_perm_in_pend: assert property (@(posedge clock) disable iff (reset)
      (pend_ff & perm_ff) == perm_ff)
      else $error("permanent event missing from pending set");

   // A transition can only fire once the machine is running.
   a_fired_running: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_fired_ff |-> out_running_ff)
      else $error("transition reported while not running");

   // Without a transition the reported index is zero.
   a_idx_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !out_fired_ff |-> out_tidx_ff == '0)
      else $error("nonzero transition index without a transition");

   // A processed start always leaves the machine running.
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      advance && in_action_ff == ACT_START |=> started_ff)
      else $error("start did not set the running flag");

endmodule

`default_nettype wire
